// ===== hw/rtl/lbm_pkg.sv =====
`default_nettype none
package lbm_pkg;

  localparam int NPOP = 9;
  localparam int WORD_W = 32;
  localparam int RELAX_W = 30;
  localparam int FRAC_BITS_DEF = 28;
  localparam logic [RELAX_W-1:0] RELAX_RESET = 30'd474267590;

  // Velocity divider: momentum magnitude width and one quotient bit per stage.
  localparam int MAG_W = 34;
  localparam int UDIV_STEPS = 33;
  localparam int UDIV_LAT = UDIV_STEPS + 2;

  // Width of rounded products and of the saturating inputs.
  localparam int PROD_W = 66;
  localparam int SAT_W = 72;

  // Divider by the constant weight denominators. Twice every denominator is
  // nine shifted left by WT_SH, so the dividend is shifted and then divided
  // by nine through a shift-and-add reciprocal with one final correction.
  localparam int CD_W = 48;
  localparam int CD_BW = 51;
  localparam int CLAMP_SH = 37;
  localparam int BIAS_SH = 36;

  localparam int DIR_X [NPOP] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
  localparam int DIR_Y [NPOP] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
  localparam int WT_NUM [NPOP] = '{4, 1, 1, 1, 1, 1, 1, 1, 1};
  localparam int WT_DEN [NPOP] = '{9, 9, 9, 9, 9, 36, 36, 36, 36};
  localparam int WT_SH [NPOP] = '{1, 1, 1, 1, 1, 3, 3, 3, 3};
  localparam int OPP [NPOP] = '{0, 3, 4, 1, 2, 7, 8, 5, 6};

  typedef logic signed [WORD_W-1:0] word_t;

  typedef enum logic [1:0] {
    KIND_FLUID    = 2'd0,
    KIND_OBSTACLE = 2'd1,
    KIND_BOTTOM   = 2'd2,
    KIND_TOP      = 2'd3
  } kind_t;

  typedef struct packed {
    word_t pop_0;
    word_t pop_1;
    word_t pop_2;
    word_t pop_3;
    word_t pop_4;
    word_t pop_5;
    word_t pop_6;
    word_t pop_7;
    word_t pop_8;
    kind_t cell_kind;
  } item_t;

  typedef struct packed {
    word_t post_0;
    word_t post_1;
    word_t post_2;
    word_t post_3;
    word_t post_4;
    word_t post_5;
    word_t post_6;
    word_t post_7;
    word_t post_8;
    word_t density;
    word_t velocity_x;
    word_t velocity_y;
  } result_t;

  typedef struct packed {
    word_t [NPOP-1:0] pop;
    kind_t kind;
    word_t rho;
    word_t ux;
    word_t uy;
  } carry_t;

  localparam logic signed [SAT_W-1:0] SMAX_W = SAT_W'(64'sh7FFF_FFFF);
  localparam logic signed [SAT_W-1:0] SMIN_W = -SMAX_W - SAT_W'(1);

  function automatic word_t sat32(input logic signed [SAT_W-1:0] v);
    word_t r;
    if (v > SMAX_W) begin
      r = SMAX_W[WORD_W-1:0];
    end else if (v < SMIN_W) begin
      r = SMIN_W[WORD_W-1:0];
    end else begin
      r = v[WORD_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/lbm_udiv.sv =====
`default_nettype none
// Pipelined fractional divider: quo = sat(+-(num * 2^FRAC_BITS / den)),
// truncated toward zero, one quotient bit per stage.
module lbm_udiv #(
  parameter int FRAC_BITS = lbm_pkg::FRAC_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic [lbm_pkg::MAG_W-1:0]  num,
  input  wire logic [lbm_pkg::WORD_W-2:0] den,
  input  wire logic                       neg,
  input  wire logic                       zero,
  output lbm_pkg::word_t                  quo
);

  localparam int STEPS = lbm_pkg::UDIV_STEPS;
  localparam int NW = lbm_pkg::MAG_W + FRAC_BITS;
  localparam int HW = NW - STEPS;
  localparam int DW = lbm_pkg::WORD_W - 1;
  localparam int CW = (HW > DW) ? HW : DW;

  logic [NW-1:0] nn;
  logic [HW-1:0] hi;

  logic [lbm_pkg::WORD_W-1:0] rem [0:STEPS];
  logic [STEPS-1:0] low [0:STEPS];
  logic [STEPS-1:0] q [0:STEPS];
  logic [DW-1:0] dn [0:STEPS];
  logic ovf [0:STEPS];
  logic sg [0:STEPS];
  logic zr [0:STEPS];

  assign nn = {num, FRAC_BITS'(0)};
  assign hi = nn[NW-1:STEPS];

  always_ff @(posedge clk) begin
    rem[0] <= lbm_pkg::WORD_W'(hi);
    low[0] <= nn[STEPS-1:0];
    q[0] <= '0;
    dn[0] <= den;
    // The quotient reaches 2^33 exactly when the upper part is not below den.
    ovf[0] <= (CW'(hi) >= CW'(den));
    sg[0] <= neg;
    zr[0] <= zero;
  end

  for (genvar j = 1; j <= STEPS; j++) begin : g_step
    logic [lbm_pkg::WORD_W:0] t;
    logic ge;
    assign t = {rem[j-1], low[j-1][STEPS-1]};
    assign ge = (t >= (lbm_pkg::WORD_W + 1)'(dn[j-1]));
    always_ff @(posedge clk) begin
      rem[j] <= ge ? lbm_pkg::WORD_W'(t - (lbm_pkg::WORD_W + 1)'(dn[j-1]))
                   : t[lbm_pkg::WORD_W-1:0];
      low[j] <= {low[j-1][STEPS-2:0], 1'b0};
      q[j] <= {q[j-1][STEPS-2:0], ge};
      dn[j] <= dn[j-1];
      ovf[j] <= ovf[j-1];
      sg[j] <= sg[j-1];
      zr[j] <= zr[j-1];
    end
  end

  localparam logic [STEPS-1:0] POS_LIM = STEPS'(33'h0_7FFF_FFFF);
  localparam logic [STEPS-1:0] NEG_LIM = STEPS'(33'h0_8000_0000);

  lbm_pkg::word_t quo_next;

  always_comb begin
    if (zr[STEPS]) begin
      quo_next = '0;
    end else if (!sg[STEPS]) begin
      if (ovf[STEPS] || (q[STEPS] > POS_LIM)) begin
        quo_next = 32'sh7FFF_FFFF;
      end else begin
        quo_next = q[STEPS][lbm_pkg::WORD_W-1:0];
      end
    end else begin
      if (ovf[STEPS] || (q[STEPS] > NEG_LIM)) begin
        quo_next = 32'sh8000_0000;
      end else begin
        quo_next = -q[STEPS][lbm_pkg::WORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    quo <= quo_next;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/lbm_d2q9_bgk_collision.sv =====
`default_nettype none
// D2Q9 BGK collision of one lattice cell per item, signed fixed point with
// FRAC_BITS fraction bits.
// Input channel: an item (nine populations and the cell kind) is taken at a
// rising edge with start high and busy low. busy is always low, so a new item
// can be taken in every cycle.
// Output channel: done is high for exactly one cycle with the result item
// (nine post-collision populations, density and velocity) on result. The
// receiver cannot stall, so nothing is held back.
// Throughput: one item per cycle. The latency is set by the two velocity
// dividers, which produce one quotient bit per pipeline stage (33 stages),
// plus the multiplier stages and a seven-stage shift-and-add divider by the
// weight denominators.
// Configuration: wr_en writes wr_data into the relaxation rate omega at the
// next edge; write it only while no item is in flight.
// Reset: rst clears the pipeline valid bits and sets omega to its default.
module lbm_d2q9_bgk_collision #(
  parameter int FRAC_BITS = lbm_pkg::FRAC_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire lbm_pkg::item_t              item,
  output logic                             done,
  output lbm_pkg::result_t                 result,
  input  wire logic                        wr_en,
  input  wire logic [lbm_pkg::RELAX_W-1:0] wr_data
);

  localparam int NPOP = lbm_pkg::NPOP;
  localparam int PW = lbm_pkg::PROD_W;
  localparam int SW = lbm_pkg::SAT_W;
  localparam int V = lbm_pkg::UDIV_LAT;
  localparam int LAST = V + 14;
  localparam int LAT = LAST + 1;

  localparam logic signed [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);
  localparam logic signed [PW-1:0] ONE = PW'(1) << FRAC_BITS;
  localparam logic signed [PW-1:0] NMAX = (PW'(1) << lbm_pkg::CLAMP_SH) - PW'(1);
  localparam logic signed [PW-1:0] NMIN = -(PW'(1) << lbm_pkg::CLAMP_SH);

  function automatic logic signed [PW-1:0] mulq(input logic signed [63:0] p);
    return (PW'(p) + HALF) >>> FRAC_BITS;
  endfunction

  logic [lbm_pkg::RELAX_W-1:0] relax;
  logic [LAST:0] vld;
  logic acc;
  lbm_pkg::carry_t cr [0:LAST-1];

  assign busy = 1'b0;
  assign acc = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      relax <= lbm_pkg::RELAX_RESET;
      vld <= '0;
    end else begin
      if (wr_en) begin
        relax <= wr_data;
      end
      vld <= {vld[LAST-1:0], acc};
    end
  end

  // Front stage: density and momenta.
  lbm_pkg::word_t pin [NPOP];
  logic signed [35:0] sum9;
  logic signed [34:0] mx_s, my_s;
  lbm_pkg::carry_t c0;

  always_comb begin
    pin[0] = item.pop_0;
    pin[1] = item.pop_1;
    pin[2] = item.pop_2;
    pin[3] = item.pop_3;
    pin[4] = item.pop_4;
    pin[5] = item.pop_5;
    pin[6] = item.pop_6;
    pin[7] = item.pop_7;
    pin[8] = item.pop_8;
    sum9 = '0;
    for (int k = 0; k < NPOP; k++) begin
      sum9 = sum9 + 36'(pin[k]);
    end
    mx_s = (35'(pin[1]) + 35'(pin[5]) + 35'(pin[8]))
         - (35'(pin[3]) + 35'(pin[6]) + 35'(pin[7]));
    my_s = (35'(pin[2]) + 35'(pin[5]) + 35'(pin[6]))
         - (35'(pin[4]) + 35'(pin[7]) + 35'(pin[8]));
    for (int k = 0; k < NPOP; k++) begin
      c0.pop[k] = pin[k];
    end
    c0.kind = item.cell_kind;
    c0.rho = lbm_pkg::sat32(SW'(sum9));
    c0.ux = '0;
    c0.uy = '0;
  end

  logic [lbm_pkg::MAG_W-1:0] mag_x, mag_y;
  logic neg_x, neg_y, rho_np;
  lbm_pkg::word_t vx, vy;

  always_ff @(posedge clk) begin
    neg_x <= mx_s[34];
    neg_y <= my_s[34];
    mag_x <= mx_s[34] ? lbm_pkg::MAG_W'(-mx_s) : lbm_pkg::MAG_W'(mx_s);
    mag_y <= my_s[34] ? lbm_pkg::MAG_W'(-my_s) : lbm_pkg::MAG_W'(my_s);
    rho_np <= (c0.rho <= 0);
  end

  // Payload line; the velocities join it once the dividers finish.
  lbm_pkg::carry_t cv;

  always_comb begin
    cv = cr[V];
    cv.ux = vx;
    cv.uy = vy;
  end

  always_ff @(posedge clk) begin
    cr[0] <= c0;
    for (int s = 1; s < LAST; s++) begin
      if (s == V + 1) begin
        cr[s] <= cv;
      end else begin
        cr[s] <= cr[s-1];
      end
    end
  end

  lbm_udiv #(.FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk  (clk),
    .num  (mag_x),
    .den  (cr[0].rho[lbm_pkg::WORD_W-2:0]),
    .neg  (neg_x),
    .zero (rho_np),
    .quo  (vx)
  );

  lbm_udiv #(.FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk  (clk),
    .num  (mag_y),
    .den  (cr[0].rho[lbm_pkg::WORD_W-2:0]),
    .neg  (neg_y),
    .zero (rho_np),
    .quo  (vy)
  );

  logic signed [63:0] pxx, pyy;
  lbm_pkg::word_t usq;

  always_ff @(posedge clk) begin
    pxx <= 64'(vx) * 64'(vx);
    pyy <= 64'(vy) * 64'(vy);
    usq <= lbm_pkg::sat32(SW'(mulq(pxx)) + SW'(mulq(pyy)));
  end

  lbm_pkg::word_t relx [NPOP];

  for (genvar k = 0; k < NPOP; k++) begin : g_dir
    localparam int CX = lbm_pkg::DIR_X[k];
    localparam int CY = lbm_pkg::DIR_Y[k];
    localparam int SH = lbm_pkg::WT_SH[k];
    localparam logic signed [47:0] WN2 = 48'(2 * lbm_pkg::WT_NUM[k]);
    localparam logic signed [47:0] WD = 48'(lbm_pkg::WT_DEN[k]);
    localparam logic signed [47:0] BIAS = 48'(2 * lbm_pkg::WT_DEN[k]) <<< lbm_pkg::BIAS_SH;
    localparam logic signed [49:0] UNBIAS = 50'(1) <<< lbm_pkg::BIAS_SH;

    logic signed [35:0] sxy;
    logic signed [PW-1:0] tn, nq, pq;
    logic signed [47:0] nc, xs;
    lbm_pkg::word_t cu1, cu2, tt, feq;
    logic signed [63:0] pcc, prt, prd;
    logic signed [32:0] diff;
    logic [lbm_pkg::CD_W-1:0] m0, m1, m2, m3, m4, q4, q5, q6, r5;
    logic [lbm_pkg::CD_BW-1:0] b1, p2, pa2, pb2, e3;

    always_comb begin
      sxy = '0;
      if (CX == 1) begin
        sxy = sxy + 36'(vx);
      end else if (CX == -1) begin
        sxy = sxy - 36'(vx);
      end
      if (CY == 1) begin
        sxy = sxy + 36'(vy);
      end else if (CY == -1) begin
        sxy = sxy - 36'(vy);
      end
      tn = (ONE <<< 1) + (PW'(cu2) <<< 1) + mulq(pcc) - PW'(usq) * PW'(3);
      nq = mulq(prt);
      // Beyond this range the weighted equilibrium saturates anyway.
      if (nq > NMAX) begin
        nc = 48'(NMAX);
      end else if (nq < NMIN) begin
        nc = 48'(NMIN);
      end else begin
        nc = 48'(nq);
      end
      // Biased so that the dividend is never negative and floor comes free.
      xs = nc * WN2 + WD + BIAS;
      diff = 33'(cr[V+12].pop[k]) - 33'(feq);
      pq = mulq(prd);
      relx[k] = lbm_pkg::sat32(SW'(cr[V+13].pop[k]) - SW'(pq));
    end

    always_ff @(posedge clk) begin
      cu1 <= lbm_pkg::sat32(SW'(sxy * 36'sd3));
      cu2 <= cu1;
      pcc <= 64'(cu1) * 64'(cu1);
      tt <= lbm_pkg::sat32(SW'((tn + PW'(1)) >>> 1));
      prt <= 64'(cr[V+3].rho) * 64'(tt);
      // 64m/9 = 7m * (1 + 2^-6 + 2^-12 + ...); the truncated series leaves
      // the estimate at most one below the true quotient.
      m0 <= lbm_pkg::CD_W'(xs >>> SH);
      b1 <= (lbm_pkg::CD_BW'(m0) << 3) - lbm_pkg::CD_BW'(m0);
      m1 <= m0;
      p2 <= b1 + (b1 >> 6) + (b1 >> 12);
      pa2 <= (b1 >> 18) + (b1 >> 24) + (b1 >> 30);
      pb2 <= (b1 >> 36) + (b1 >> 42) + (b1 >> 48);
      m2 <= m1;
      e3 <= p2 + pa2 + pb2;
      m3 <= m2;
      q4 <= lbm_pkg::CD_W'(e3 >> 6);
      m4 <= m3;
      r5 <= m4 - ((q4 << 3) + q4);
      q5 <= q4;
      q6 <= q5 + lbm_pkg::CD_W'(r5 >= lbm_pkg::CD_W'(9));
      feq <= lbm_pkg::sat32(SW'($signed({2'b00, q6}) - UNBIAS));
      prd <= 64'($signed({1'b0, relax})) * 64'(diff);
    end
  end

  lbm_pkg::word_t post_sel [NPOP];
  lbm_pkg::carry_t cf;

  always_comb begin
    cf = cr[LAST-1];
    for (int k = 0; k < NPOP; k++) begin
      post_sel[k] = relx[k];
    end
    unique case (cf.kind)
      lbm_pkg::KIND_FLUID: begin
      end
      lbm_pkg::KIND_OBSTACLE: begin
        for (int k = 1; k < NPOP; k++) begin
          post_sel[k] = cf.pop[lbm_pkg::OPP[k]];
        end
      end
      lbm_pkg::KIND_BOTTOM: begin
        post_sel[2] = cf.pop[4];
        post_sel[5] = cf.pop[7];
        post_sel[6] = cf.pop[8];
      end
      lbm_pkg::KIND_TOP: begin
        post_sel[4] = cf.pop[2];
        post_sel[7] = cf.pop[5];
        post_sel[8] = cf.pop[6];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    result.post_0 <= post_sel[0];
    result.post_1 <= post_sel[1];
    result.post_2 <= post_sel[2];
    result.post_3 <= post_sel[3];
    result.post_4 <= post_sel[4];
    result.post_5 <= post_sel[5];
    result.post_6 <= post_sel[6];
    result.post_7 <= post_sel[7];
    result.post_8 <= post_sel[8];
    result.density <= cf.rho;
    result.velocity_x <= cf.ux;
    result.velocity_y <= cf.uy;
  end

  assign done = vld[LAST];

  a_latency: assert property (@(posedge clk) disable iff (rst)
    acc |-> ##LAT done) else $error("accepted item produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(acc, LAT)) else $error("result without an accepted item");

  a_obstacle: assert property (@(posedge clk) disable iff (rst)
    done && ($past(item.cell_kind, LAT) == lbm_pkg::KIND_OBSTACLE)
      |-> result.post_1 == $past(item.pop_3, LAT))
    else $error("obstacle bounce-back mismatch");

  a_zero_vel: assert property (@(posedge clk) disable iff (rst)
    done && (result.density <= 0)
      |-> (result.velocity_x == 0) && (result.velocity_y == 0))
    else $error("velocity nonzero at nonpositive density");

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;

  localparam int FB = 28;
  localparam int LATENCY = 50;
  localparam int WATCHDOG_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  lbm_pkg::item_t item = '0;
  logic done;
  lbm_pkg::result_t result;
  logic wr_en = 1'b0;
  logic [lbm_pkg::RELAX_W-1:0] wr_data = '0;

  lbm_d2q9_bgk_collision #(.FRAC_BITS(FB)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .wr_en(wr_en), .wr_data(wr_data)
  );

  always #6 clk = ~clk;

  lbm_pkg::result_t expected_cells[$];
  logic [lbm_pkg::RELAX_W-1:0] omega_model = lbm_pkg::RELAX_RESET;
  int mismatches = 0;
  int idle_cycles = 0;
  bit idle_free = 1'b0;
  bit timed_out = 1'b0;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint shr_floor(longint x, int s);
    return x >>> s;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return shr_floor(a * b + (64'sd1 <<< (FB - 1)), FB);
  endfunction

  function automatic longint div_floor(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic longint round_half_up(longint n, longint d);
    return div_floor(2 * n + d, 2 * d);
  endfunction

  function automatic longint velocity_div(longint num, longint den);
    bit neg;
    longint unsigned n, d, q, r, cap;
    neg = num < 0;
    n = neg ? -num : num;
    d = den;
    cap = 64'd4294967296;
    q = n / d;
    r = n % d;
    if (q > cap) q = cap;
    for (int i = 0; i < FB; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 1;
      end
      if (q > cap) q = cap;
    end
    return neg ? clamp32(-longint'(q)) : clamp32(longint'(q));
  endfunction

  function automatic lbm_pkg::result_t collide_cell(lbm_pkg::item_t it);
    longint f[lbm_pkg::NPOP], post[lbm_pkg::NPOP];
    longint sum, mx, my, rho, ux, uy, usq, cu, t, feq, om;
    lbm_pkg::word_t w[lbm_pkg::NPOP];
    lbm_pkg::result_t r;
    w = '{it.pop_0, it.pop_1, it.pop_2, it.pop_3, it.pop_4, it.pop_5, it.pop_6,
          it.pop_7, it.pop_8};
    sum = 0;
    ux = 0;
    uy = 0;
    for (int k = 0; k < lbm_pkg::NPOP; k++) begin
      f[k] = longint'(w[k]);
      sum += f[k];
    end
    rho = clamp32(sum);
    mx = (f[1] + f[5] + f[8]) - (f[3] + f[6] + f[7]);
    my = (f[2] + f[5] + f[6]) - (f[4] + f[7] + f[8]);
    if (rho > 0) begin
      ux = velocity_div(mx, rho);
      uy = velocity_div(my, rho);
    end
    usq = clamp32(qmul(ux, ux) + qmul(uy, uy));
    om = longint'({34'd0, omega_model});
    for (int k = 0; k < lbm_pkg::NPOP; k++) begin
      cu = clamp32(3 * (lbm_pkg::DIR_X[k] * ux + lbm_pkg::DIR_Y[k] * uy));
      t = clamp32(round_half_up((64'sd2 <<< FB) + 2 * cu + qmul(cu, cu) - 3 * usq, 2));
      feq = clamp32(round_half_up(qmul(rho, t) * lbm_pkg::WT_NUM[k],
                                  lbm_pkg::WT_DEN[k]));
      post[k] = clamp32(f[k] - qmul(om, f[k] - feq));
    end
    case (it.cell_kind)
      lbm_pkg::KIND_OBSTACLE: begin
        for (int k = 1; k < lbm_pkg::NPOP; k++) post[k] = f[lbm_pkg::OPP[k]];
      end
      lbm_pkg::KIND_BOTTOM: begin
        post[2] = f[4];
        post[5] = f[7];
        post[6] = f[8];
      end
      lbm_pkg::KIND_TOP: begin
        post[4] = f[2];
        post[7] = f[5];
        post[8] = f[6];
      end
      default: ;
    endcase
    r.post_0 = 32'(post[0]); r.post_1 = 32'(post[1]); r.post_2 = 32'(post[2]);
    r.post_3 = 32'(post[3]); r.post_4 = 32'(post[4]); r.post_5 = 32'(post[5]);
    r.post_6 = 32'(post[6]); r.post_7 = 32'(post[7]); r.post_8 = 32'(post[8]);
    r.density = 32'(rho);
    r.velocity_x = 32'(ux);
    r.velocity_y = 32'(uy);
    return r;
  endfunction

  function automatic void add_expected(lbm_pkg::result_t r);
    expected_cells = {expected_cells, r};
  endfunction

  // Results are sampled on the edge that ends their strobe cycle.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_cells.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", result);
      end else begin
        lbm_pkg::result_t e;
        e = expected_cells.pop_front();
        if (e !== result) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at %0t", $realtime);
            $display("  expected %h", e);
            $display("  actual   %h", result);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || done || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("lbm_d2q9_bgk_collision regression: fail");
      $finish;
    end
  end

  // start stays high after the accepting edge; the next call either idles
  // or presents its own item, and drain drops it.
  task automatic send_cell(lbm_pkg::item_t it);
    if (!idle_free) begin
      while ($urandom_range(99) < 29) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start <= 1'b1;
    item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    add_expected(collide_cell(it));
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic set_omega(logic [lbm_pkg::RELAX_W-1:0] v);
    wr_en <= 1'b1;
    wr_data <= v;
    omega_model = v;
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  function automatic lbm_pkg::item_t make_cell(
      lbm_pkg::word_t p0, lbm_pkg::word_t p1, lbm_pkg::word_t p2,
      lbm_pkg::word_t p3, lbm_pkg::word_t p4, lbm_pkg::word_t p5,
      lbm_pkg::word_t p6, lbm_pkg::word_t p7, lbm_pkg::word_t p8,
      lbm_pkg::kind_t kd);
    lbm_pkg::item_t it;
    it.pop_0 = p0; it.pop_1 = p1; it.pop_2 = p2; it.pop_3 = p3; it.pop_4 = p4;
    it.pop_5 = p5; it.pop_6 = p6; it.pop_7 = p7; it.pop_8 = p8;
    it.cell_kind = kd;
    return it;
  endfunction

  // Populations near equilibrium of a slow flow, which is how real lattices look.
  function automatic lbm_pkg::item_t physical_cell();
    lbm_pkg::word_t p[lbm_pkg::NPOP];
    int base;
    base = $urandom_range(1 << 28, 1 << 26);
    for (int k = 0; k < lbm_pkg::NPOP; k++) begin
      p[k] = base * lbm_pkg::WT_NUM[k] / lbm_pkg::WT_DEN[k] +
             $signed($urandom_range(1 << 22)) - (1 << 21);
    end
    return make_cell(p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7], p[8],
                     lbm_pkg::kind_t'($urandom_range(3)));
  endfunction

  function automatic lbm_pkg::item_t noise_cell();
    lbm_pkg::item_t it;
    it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
          $urandom, $urandom, 2'($urandom)};
    return it;
  endfunction

  task automatic test_directed;
    lbm_pkg::word_t mx, mn, one;
    mx = 32'sh7FFF_FFFF;
    mn = 32'sh8000_0000;
    one = 32'sh1000_0000;
    for (int kd = 0; kd < 4; kd++) begin
      send_cell(make_cell(one, one, one, one, one, one, one, one, one,
                          lbm_pkg::kind_t'(kd)));
      send_cell(make_cell(1, 2, 3, 4, 5, 6, 7, 8, 9, lbm_pkg::kind_t'(kd)));
    end
    send_cell(make_cell(0, 0, 0, 0, 0, 0, 0, 0, 0, lbm_pkg::KIND_FLUID));
    send_cell(make_cell(mx, mx, mx, mx, mx, mx, mx, mx, mx, lbm_pkg::KIND_FLUID));
    send_cell(make_cell(mn, mn, mn, mn, mn, mn, mn, mn, mn, lbm_pkg::KIND_FLUID));
    // Zero density leaves the velocity at zero.
    send_cell(make_cell(-one, one, 0, 0, 0, 0, 0, 0, 0, lbm_pkg::KIND_FLUID));
    // A tiny density against a large momentum saturates the quotient.
    send_cell(make_cell(-mx, mx, 0, 0, 0, 0, 0, 0, 1, lbm_pkg::KIND_FLUID));
    send_cell(make_cell(mx, mx, mn, mn, 0, mx, 0, mn, 0, lbm_pkg::KIND_FLUID));
    send_cell(make_cell(0, mx, mx, mn, mn, mx, mn, mn, mx, lbm_pkg::KIND_OBSTACLE));
    send_cell(make_cell(0, 0, mx, 0, mn, mx, mx, mn, mn, lbm_pkg::KIND_BOTTOM));
    send_cell(make_cell(0, 0, mn, 0, mx, mn, mn, mx, mx, lbm_pkg::KIND_TOP));
    send_cell(make_cell(one, 0, 0, 0, 0, 1, 0, 0, 0, lbm_pkg::KIND_FLUID));
    drain();
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      idle_free = (i >= count / 3) && (i < count / 3 + 120);
      if ($urandom_range(99) < 80) send_cell(physical_cell());
      else send_cell(noise_cell());
    end
    idle_free = 1'b0;
    drain();
  endtask

  task automatic test_omega_sweep;
    logic [lbm_pkg::RELAX_W-1:0] rates[5];
    rates = '{30'd0, 30'd536870912, 30'h3FFF_FFFF, 30'd268435456,
              lbm_pkg::RELAX_RESET};
    foreach (rates[i]) begin
      set_omega(rates[i]);
      test_random(200);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(250);
    test_omega_sweep();
    if (mismatches == 0) $display("lbm_d2q9_bgk_collision regression: pass");
    else $display("lbm_d2q9_bgk_collision regression: fail");
    $finish;
  end
endmodule

// ===== filelist.f =====
hw/rtl/lbm_pkg.sv
hw/rtl/lbm_udiv.sv
hw/rtl/lbm_d2q9_bgk_collision.sv
tb/testbench.sv
